// ===== design/top_down_first_fit_allocator_core_assert.svh =====
// Assertion macros for the allocator checker (tdfa_checker).
`ifndef TOP_DOWN_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define TOP_DOWN_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Clocked assertion, masked while reset is active.
`define TDFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is active.
`define TDFA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tdfa_pkg
// Constants and types for the top-down first-fit allocator.
// ----------------------------------------------------------------------------
package tdfa_pkg;

    localparam int MAX_BLOCKS   = 16;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W       = 16;
    localparam int HEADER_BYTES = 40;
    localparam int ENTRY_BYTES  = 32;
    localparam int GUARD_BYTES  = 4;
    localparam int OVERHEAD     = HEADER_BYTES + ENTRY_BYTES - 2 * GUARD_BYTES;
    localparam logic [15:0] POOL_RESET = 16'd4096;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              swap_en;
        logic              parity;
        logic              load_en;
        logic [IDX_W-1:0]  load_idx;
        logic [15:0]       load_start;
        logic [15:0]       load_size;
    } cell_cmd_t;

endpackage

// ===== design/tdfa_cell.sv =====
// ----------------------------------------------------------------------------
// tdfa_cell
// One table slot: compare-swap with neighbors, gap fit and address match.
// ----------------------------------------------------------------------------
module tdfa_cell
(
    input  logic                        clk,
    input  logic [tdfa_pkg::IDX_W-1:0]  cell_idx,
    input  tdfa_pkg::cell_cmd_t         cmd,
    input  logic [tdfa_pkg::CNT_W-1:0]  count,
    input  logic [16:0]                 actual,
    input  logic [15:0]                 faddr,
    input  logic [15:0]                 above_start,
    input  logic [15:0]                 above_size,
    input  logic [15:0]                 below_start,
    input  logic [15:0]                 below_size,
    output logic [15:0]                 start,
    output logic [15:0]                 size,
    output logic                        fit,
    output logic                        match
);

    logic [15:0] start_reg, start_next;
    logic [15:0] size_reg, size_next;
    logic        in_use;
    logic        below_in_use;
    logic [16:0] low;
    logic [16:0] high;
    logic [15:0] user_addr;

    assign in_use       = {1'b0, cell_idx} < count;
    assign below_in_use = ({1'b0, cell_idx} + tdfa_pkg::CNT_W'(1)) < count;

    always_comb
    begin
        start_next = start_reg;
        size_next  = size_reg;
        if (cmd.swap_en)
        begin
            if (cell_idx[0] == cmd.parity)
            begin
                // upper slot of the pair
                if (below_in_use && (start_reg < below_start))
                begin
                    start_next = below_start;
                    size_next  = below_size;
                end
            end
            else if ((cell_idx != '0) && in_use && (above_start < start_reg))
            begin
                start_next = above_start;
                size_next  = above_size;
            end
        end
        if (cmd.load_en && (cmd.load_idx == cell_idx))
        begin
            start_next = cmd.load_start;
            size_next  = cmd.load_size;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        size_reg  <= size_next;
    end

    assign low       = {1'b0, start_reg} + {1'b0, size_reg};
    assign high      = {1'b0, above_start};
    assign fit       = in_use && (low <= high) && ((high - low) >= actual);
    assign user_addr = start_reg + 16'(tdfa_pkg::GUARD_BYTES);
    assign match     = in_use && (user_addr == faddr);
    assign start     = start_reg;
    assign size      = size_reg;

endmodule

// ===== design/top_down_first_fit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// top_down_first_fit_allocator_core: one word per request, one result word.
// An alloc into a non-empty table runs 16 odd-even sort passes, then scans and places.
// First, too-large or full alloc skips the sort; a free scans without sorting; output stalls delay the result.
// One word at a time: the next word can be taken in the same cycle as the result is presented.
// Reset clears control, the block count and restores pool_reg to 4096.
// ----------------------------------------------------------------------------
module top_down_first_fit_allocator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] request_bytes,
    input  logic [15:0] free_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] user_address,
    output logic [4:0]  blocks_in_use
);

    localparam int N  = tdfa_pkg::MAX_BLOCKS;
    localparam int IW = tdfa_pkg::IDX_W;
    localparam int CW = tdfa_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_SORT   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_PLACE  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [15:0]    pool_reg, pool_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  pass_reg, pass_next;
    logic           op_reg, op_next;
    logic [16:0]    actual_reg, actual_next;
    logic [15:0]    faddr_reg, faddr_next;
    logic [2:0]     res_status_reg, res_status_next;
    logic [15:0]    res_start_reg, res_start_next;
    logic [IW-1:0]  res_idx_reg, res_idx_next;
    logic           out_valid_reg, out_valid_next;
    logic [2:0]     status_reg, status_next;
    logic [15:0]    addr_reg, addr_next;
    logic [4:0]     blocks_reg, blocks_next;

    logic [15:0]    c_start [N];
    logic [15:0]    c_size  [N];
    logic [N-1:0]   c_fit;
    logic [N-1:0]   c_match;
    tdfa_pkg::cell_cmd_t cmd;

    logic           fit_any, match_any;
    logic [IW-1:0]  fit_idx, match_idx;
    logic [IW-1:0]  last_idx;
    logic [16:0]    too_big_sum;
    logic [16:0]    ctrl_end;
    logic           out_free;
    logic           commit;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            logic [15:0] a_start, a_size, b_start, b_size;
            if (k == 0)
            begin : g_top
                assign a_start = pool_reg;
                assign a_size  = '0;
            end
            else
            begin : g_mid
                assign a_start = c_start[k-1];
                assign a_size  = c_size[k-1];
            end
            if (k == N - 1)
            begin : g_bot
                assign b_start = '0;
                assign b_size  = '0;
            end
            else
            begin : g_nbot
                assign b_start = c_start[k+1];
                assign b_size  = c_size[k+1];
            end
            tdfa_cell u_cell
            (
                .clk         (clk),
                .cell_idx    (IW'(k)),
                .cmd         (cmd),
                .count       (count_reg),
                .actual      (actual_reg),
                .faddr       (faddr_reg),
                .above_start (a_start),
                .above_size  (a_size),
                .below_start (b_start),
                .below_size  (b_size),
                .start       (c_start[k]),
                .size        (c_size[k]),
                .fit         (c_fit[k]),
                .match       (c_match[k])
            );
        end
    endgenerate

    // lowest-index hit wins
    always_comb
    begin
        fit_any   = 1'b0;
        match_any = 1'b0;
        fit_idx   = '0;
        match_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (c_fit[i])
            begin
                fit_any = 1'b1;
                fit_idx = IW'(i);
            end
            if (c_match[i])
            begin
                match_any = 1'b1;
                match_idx = IW'(i);
            end
        end
    end

    assign last_idx    = IW'(count_reg - CW'(1));
    assign too_big_sum = {1'b0, request_bytes} + 17'(tdfa_pkg::OVERHEAD);
    assign ctrl_end    = 17'(tdfa_pkg::HEADER_BYTES + tdfa_pkg::ENTRY_BYTES)
                       + 17'(count_reg) * 17'(tdfa_pkg::ENTRY_BYTES);
    assign out_free    = !out_valid_reg || !out_stall;
    assign commit      = (state_reg == S_RESULT) && out_free
                       && (res_status_reg == tdfa_pkg::ST_OK);

    always_comb
    begin
        cmd            = '0;
        cmd.swap_en    = (state_reg == S_SORT);
        cmd.parity     = pass_reg[0];
        cmd.load_en    = commit;
        if (op_reg == tdfa_pkg::OP_ALLOC)
        begin
            cmd.load_idx   = IW'(count_reg);
            cmd.load_start = res_start_reg;
            cmd.load_size  = actual_reg[15:0];
        end
        else
        begin
            cmd.load_idx   = res_idx_reg;
            cmd.load_start = c_start[last_idx];
            cmd.load_size  = c_size[last_idx];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pool_next       = pool_reg;
        count_next      = count_reg;
        pass_next       = pass_reg;
        op_next         = op_reg;
        actual_next     = actual_reg;
        faddr_next      = faddr_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        blocks_next     = blocks_reg;

        if (cfg_we)
            pool_next = cfg_wdata;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = operation;
                    actual_next = {1'b0, request_bytes} + 17'(2 * tdfa_pkg::GUARD_BYTES);
                    faddr_next  = free_address;
                    res_status_next = (too_big_sum > {1'b0, pool_reg})
                                    ? tdfa_pkg::ST_TOO_LARGE : tdfa_pkg::ST_OK;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                pass_next = '0;
                if (op_reg == tdfa_pkg::OP_FREE)
                    state_next = S_SCAN;
                else if (res_status_reg == tdfa_pkg::ST_TOO_LARGE)
                    state_next = S_RESULT;
                else if (count_reg >= CW'(N))
                begin
                    res_status_next = tdfa_pkg::ST_FULL;
                    state_next      = S_RESULT;
                end
                else if (count_reg == '0)
                begin
                    if (actual_reg >= {1'b0, pool_reg})
                        res_status_next = tdfa_pkg::ST_NO_SPACE;
                    res_start_next = 16'({1'b0, pool_reg} - actual_reg);
                    state_next     = S_RESULT;
                end
                else
                    state_next = S_SORT;
            end
            S_SORT:
            begin
                pass_next = pass_reg + IW'(1);
                if (pass_reg == IW'(N - 1))
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (op_reg == tdfa_pkg::OP_FREE)
                begin
                    res_idx_next    = match_idx;
                    res_status_next = match_any ? tdfa_pkg::ST_OK : tdfa_pkg::ST_NOT_FOUND;
                    state_next      = S_RESULT;
                end
                else
                begin
                    if (fit_any)
                        res_start_next = c_start[fit_idx] + c_size[fit_idx];
                    else
                    begin
                        if ({1'b0, c_start[last_idx]} < actual_reg)
                            res_status_next = tdfa_pkg::ST_NO_SPACE;
                        res_start_next = 16'({1'b0, c_start[last_idx]} - actual_reg);
                    end
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                // control table grows up into the region
                if (ctrl_end > {1'b0, res_start_reg})
                    res_status_next = tdfa_pkg::ST_NO_SPACE;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    addr_next      = '0;
                    if (res_status_reg == tdfa_pkg::ST_OK)
                    begin
                        if (op_reg == tdfa_pkg::OP_ALLOC)
                        begin
                            count_next = count_reg + CW'(1);
                            addr_next  = res_start_reg + 16'(tdfa_pkg::GUARD_BYTES);
                        end
                        else
                            count_next = count_reg - CW'(1);
                    end
                    blocks_next = 5'(count_next);
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_reg      <= tdfa_pkg::POOL_RESET;
            count_reg     <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        actual_reg     <= actual_next;
        faddr_reg      <= faddr_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_idx_reg    <= res_idx_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        blocks_reg     <= blocks_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign user_address  = addr_reg;
    assign blocks_in_use = blocks_reg;

endmodule

// ===== design/tdfa_checker.sv =====
// ----------------------------------------------------------------------------
// tdfa_checker
// Port-level checks on the allocator result channel.
// ----------------------------------------------------------------------------
`include "top_down_first_fit_allocator_core_assert.svh"

module tdfa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [15:0] user_address,
    input logic [4:0]  blocks_in_use
);

    `TDFA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(user_address) && $stable(blocks_in_use), "result word changed while stalled")
    `TDFA_ASSERT(a_status_range, out_valid |-> status <= tdfa_pkg::ST_NOT_FOUND, "bad status code")
    `TDFA_ASSERT(a_fail_addr, out_valid && status != tdfa_pkg::ST_OK |-> user_address == '0, "address on failure")
    `TDFA_ASSERT(a_blocks_max, out_valid |-> blocks_in_use <= 5'(tdfa_pkg::MAX_BLOCKS), "block count too high")
    `TDFA_ASSERT_RST(a_reset_quiet, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind top_down_first_fit_allocator_core tdfa_checker u_tdfa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .user_address  (user_address),
    .blocks_in_use (blocks_in_use)
);
